[hw/rtl/kmdg_pkg.sv]
// Shared types and constants for the key matrix debounce and ghost block.
// No dependencies.
`default_nettype none

package kmdg_pkg;

    localparam int KEY_BITS  = 64;
    localparam int STATUS_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [STATUS_W-1:0] GHOST_TICKS_RESET    = 8'd10;
    localparam logic [STATUS_W-1:0] DEBOUNCE_TICKS_RESET = 8'd25;

    localparam logic [CFG_IDX_W-1:0] REG_GHOST_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [STATUS_W-1:0] debounce;
    } kmdg_entry_t;

    typedef struct packed {
        logic resolve;
        logic key_open;
        logic crowded;
    } kmdg_key_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/key_matrix_debounce_ghost.sv]
// Each scan uses the one-read one-write key state memory in two passes: one pass reads
// and writes every key, a second pass resolves ghosts. A new scan is taken only in the idle
// state, after the result is loaded into the output register when that register is free.
// A finished result waits in the output register while the next scan is taken.
// Reset: async active low; per-entry valid flags make every key read as open at once,
// no clearing pass. Registers reset to ghost_ticks 10, debounce_ticks 25.
`default_nettype none

module key_matrix_debounce_ghost
    import kmdg_pkg::*;
#(
    parameter int MATRIX_SIDE = 8
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire [CFG_IDX_W-1:0]     cfg_index,
    input  wire [STATUS_W-1:0]      cfg_data,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire [71:0]              s_tdata,   // key_open_bits[63:0], extra_key_open[64]
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [135:0]            m_tdata    // settled_bits[63:0], pending_bits[127:64],
                                               // extra_key_pressed[128]
);

    localparam int SLOTS = MATRIX_SIDE * MATRIX_SIDE;
    localparam int SW    = $clog2(SLOTS);
    localparam int RW    = $clog2(MATRIX_SIDE);
    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
    localparam logic [RW-1:0] COL_LAST  = RW'(MATRIX_SIDE - 1);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_RESOLVE = 5'b00100,
        ST_FINISH  = 5'b01000,
        ST_LOAD    = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [RW-1:0]       col_reg, col_next;
    logic                p_valid_reg;
    logic                p_resolve_reg;
    logic [SW-1:0]       p_slot_reg;
    logic [RW-1:0]       p_row_reg;
    logic [RW-1:0]       p_col_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic                rd_valid_reg;
    kmdg_entry_t         rd_q_reg;
    kmdg_entry_t         mem [SLOTS];
    logic [1:0]          row_pop_reg [MATRIX_SIDE];
    logic [1:0]          col_pop_reg [MATRIX_SIDE];
    logic [KEY_BITS-1:0] keys_reg;
    logic [STATUS_W-1:0] ghost_ticks_reg;
    logic [STATUS_W-1:0] debounce_ticks_reg;
    kmdg_entry_t         extra_reg;
    logic [KEY_BITS-1:0] settled_acc_reg;
    logic [KEY_BITS-1:0] pending_acc_reg;
    logic                extra_acc_reg;
    logic                m_tvalid_reg;
    logic [128:0]        m_data_reg;

    logic                issue;
    logic                last_slot;
    logic                accept;
    logic                out_free;
    kmdg_entry_t         cur_entry;
    kmdg_entry_t         upd_entry;
    kmdg_key_ctl_t       key_ctl;
    kmdg_entry_t         extra_upd;
    kmdg_key_ctl_t       extra_ctl;

    assign issue     = (state_reg == ST_SCAN) || (state_reg == ST_RESOLVE);
    assign last_slot = (slot_reg == SLOT_LAST);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cur_entry = rd_valid_reg ? rd_q_reg : '0;

    assign key_ctl.resolve  = p_resolve_reg;
    assign key_ctl.key_open = keys_reg[p_slot_reg];
    assign key_ctl.crowded  = row_pop_reg[p_row_reg][1] && col_pop_reg[p_col_reg][1];

    kmdg_key_update u_key_update (
        .ctl            (key_ctl),
        .ghost_ticks    (ghost_ticks_reg),
        .debounce_ticks (debounce_ticks_reg),
        .entry_in       (cur_entry),
        .entry_out      (upd_entry)
    );

    assign extra_ctl.resolve  = 1'b0;
    assign extra_ctl.key_open = s_tdata[64];
    assign extra_ctl.crowded  = 1'b0;

    kmdg_key_update u_extra_update (
        .ctl            (extra_ctl),
        .ghost_ticks    (ghost_ticks_reg),
        .debounce_ticks (debounce_ticks_reg),
        .entry_in       (extra_reg),
        .entry_out      (extra_upd)
    );

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (issue)
        begin
            slot_next = slot_reg + SW'(1);
            if (col_reg == COL_LAST)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + RW'(1);
            end
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SCAN;
                slot_next = '0;
                row_next  = '0;
                col_next  = '0;
            end
            ST_SCAN:
            begin
                if (last_slot)
                begin
                    state_next = ST_RESOLVE;
                    slot_next  = '0;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_RESOLVE:
            begin
                if (last_slot)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            p_valid_reg   <= 1'b0;
            p_resolve_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            p_valid_reg   <= issue;
            p_resolve_reg <= (state_reg == ST_RESOLVE);
            if (issue)
                rd_valid_reg <= valid_reg[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        p_slot_reg <= slot_reg;
        p_row_reg  <= row_reg;
        p_col_reg  <= col_reg;
        if (accept)
            keys_reg <= s_tdata[KEY_BITS-1:0];
    end

    // key state memory: read-modify-write, one entry per cycle
    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
            mem[p_slot_reg] <= upd_entry;
        if (issue)
            rd_q_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (p_valid_reg)
            valid_reg[p_slot_reg] <= 1'b1;
    end

    // saturating row and column counts of active keys
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MATRIX_SIDE; i++)
            begin
                row_pop_reg[i] <= '0;
                col_pop_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < MATRIX_SIDE; i++)
            begin
                row_pop_reg[i] <= '0;
                col_pop_reg[i] <= '0;
            end
        end
        else if (p_valid_reg && !p_resolve_reg && (upd_entry.status != '0))
        begin
            if (!row_pop_reg[p_row_reg][1])
                row_pop_reg[p_row_reg] <= row_pop_reg[p_row_reg] + 2'd1;
            if (!col_pop_reg[p_col_reg][1])
                col_pop_reg[p_col_reg] <= col_pop_reg[p_col_reg] + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ghost_ticks_reg    <= GHOST_TICKS_RESET;
            debounce_ticks_reg <= DEBOUNCE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GHOST_TICKS:    ghost_ticks_reg    <= cfg_data;
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // extra key settles at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_reg     <= '0;
            extra_acc_reg <= 1'b0;
        end
        else if (accept)
        begin
            extra_reg.debounce <= extra_upd.debounce;
            extra_reg.status   <= (extra_upd.status > 8'd1) ? 8'd1 : extra_upd.status;
            extra_acc_reg      <= (extra_upd.status != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            settled_acc_reg <= '0;
            pending_acc_reg <= '0;
        end
        else if (p_valid_reg && p_resolve_reg)
        begin
            settled_acc_reg[p_slot_reg] <= (upd_entry.status == 8'd1);
            pending_acc_reg[p_slot_reg] <= (upd_entry.status > 8'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (state_reg == ST_LOAD && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && out_free)
            m_data_reg <= {extra_acc_reg, pending_acc_reg, settled_acc_reg};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN))
        else $error("transfer did not start a scan pass");

    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && issue) |-> (p_slot_reg != slot_reg))
        else $error("read and write-back hit the same key entry");

    a_load_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !p_valid_reg)
        else $error("result loaded while a key update is in flight");

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_LOAD))
        else $error("output valid raised outside the load state");
`endif

endmodule

`default_nettype wire

[hw/rtl/kmdg_key_update.sv]
// Per-key status update: scan step (press, debounce, release) or resolve step
// (ghost hold and settle countdown). Depends on kmdg_pkg.
`default_nettype none

module kmdg_key_update
    import kmdg_pkg::*;
(
    input  wire kmdg_key_ctl_t       ctl,
    input  wire [STATUS_W-1:0]       ghost_ticks,
    input  wire [STATUS_W-1:0]       debounce_ticks,
    input  wire kmdg_entry_t         entry_in,
    output kmdg_entry_t              entry_out
);

    logic [STATUS_W-1:0] press;
    logic [STATUS_W-1:0] deb_dec;

    assign press   = (ghost_ticks == '1) ? '1 : ghost_ticks + 8'd1;
    assign deb_dec = (entry_in.debounce != '0) ? entry_in.debounce - 8'd1 : '0;

    always_comb
    begin
        entry_out = entry_in;
        if (ctl.resolve)
        begin
            if (entry_in.status > 8'd1)
            begin
                if (ctl.crowded)
                begin
                    if (entry_in.debounce != '0)
                        entry_out.status = press;
                    else if (entry_in.status > 8'd2)
                        entry_out.status = entry_in.status - 8'd1;
                end
                else
                begin
                    entry_out.status = entry_in.status - 8'd1;
                end
            end
        end
        else
        begin
            entry_out.debounce = deb_dec;
            if (ctl.key_open)
            begin
                if (deb_dec == '0)
                    entry_out.status = '0;
            end
            else if (entry_in.status == '0)
            begin
                entry_out.status   = press;
                entry_out.debounce = debounce_ticks;
            end
        end
    end

endmodule

`default_nettype wire

[dv/tb_key_matrix_debounce_ghost.sv]
`timescale 1ns / 100ps
// Self-checking testbench for key_matrix_debounce_ghost: drives key matrix scans,
// predicts the settled and pending masks per scan and compares each output transfer.
// Depends on kmdg_pkg and the key_matrix_debounce_ghost top level.

module tb_key_matrix_debounce_ghost;
    import kmdg_pkg::*;

    localparam int SIDE           = 8;
    localparam int SLOTS          = 65;
    localparam int EXTRA_SLOT     = 64;
    localparam int LATENCY        = 2 * SIDE * SIDE + 2;
    localparam int RX_HOLD_CYCLES = 1500;
    localparam int PHASE_SCANS    = 72;
    localparam int WATCHDOG_NS    = 60_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic                extra_pressed;
        logic [KEY_BITS-1:0] pending;
        logic [KEY_BITS-1:0] settled;
    } key_report_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [STATUS_W-1:0]  cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [71:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [135:0]         m_tdata;

    logic [STATUS_W-1:0] key_level   [SLOTS];
    logic [STATUS_W-1:0] bounce_left [SLOTS];
    logic [STATUS_W-1:0] ghost_cfg;
    logic [STATUS_W-1:0] debounce_cfg;

    key_report_t predicted_reports [$];
    key_report_t oldest_report;
    int          error_count;
    int          burst_left;
    int          phase_sent;
    bit          rx_hold_req;

    key_matrix_debounce_ghost #(
        .MATRIX_SIDE(SIDE)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [STATUS_W-1:0] press_level();
        return (ghost_cfg == 8'hFF) ? 8'hFF : ghost_cfg + 8'd1;
    endfunction

    function automatic void age_key(input int slot, input logic open);
        if (bounce_left[slot] != 0)
            bounce_left[slot] = bounce_left[slot] - 8'd1;
        if (open)
        begin
            if (bounce_left[slot] == 0)
                key_level[slot] = '0;
        end
        else if (key_level[slot] == 0)
        begin
            key_level[slot]   = press_level();
            bounce_left[slot] = debounce_cfg;
        end
    endfunction

    function automatic key_report_t debounce_scan(input logic [KEY_BITS-1:0] open_bits,
                                                  input logic extra_open);
        int                  row_pop [SIDE];
        int                  col_pop [SIDE];
        int                  slot;
        logic [STATUS_W-1:0] lvl;
        key_report_t         rep;
        rep = '0;
        for (int i = 0; i < SIDE; i++)
        begin
            row_pop[i] = 0;
            col_pop[i] = 0;
        end
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                slot = (r * SIDE + c) % 64;
                age_key(slot, open_bits[slot]);
                if (key_level[slot] != 0)
                begin
                    row_pop[r]++;
                    col_pop[c]++;
                end
            end
        end
        age_key(EXTRA_SLOT, extra_open);
        if (key_level[EXTRA_SLOT] > 1)
            key_level[EXTRA_SLOT] = 8'd1;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                slot = (r * SIDE + c) % 64;
                lvl  = key_level[slot];
                if (lvl > 1)
                begin
                    if (row_pop[r] > 1 && col_pop[c] > 1)
                    begin
                        if (bounce_left[slot] != 0)
                            key_level[slot] = press_level();
                        else if (lvl > 2)
                            key_level[slot] = lvl - 8'd1;
                    end
                    else
                        key_level[slot] = lvl - 8'd1;
                end
                if (key_level[slot] == 1)
                    rep.settled[slot] = 1'b1;
                else if (key_level[slot] > 1)
                    rep.pending[slot] = 1'b1;
            end
        end
        rep.extra_pressed = (key_level[EXTRA_SLOT] == 1);
        return rep;
    endfunction

    task automatic send_scan(input logic [KEY_BITS-1:0] open_bits, input logic extra_open);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, extra_open, open_bits};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted_reports.push_back(debounce_scan(open_bits, extra_open));
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STATUS_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GHOST_TICKS)
            ghost_cfg = val;
        else if (idx == REG_DEBOUNCE_TICKS)
            debounce_cfg = val;
    endtask

    task automatic feed_scan(input logic [KEY_BITS-1:0] open_bits, input logic extra_open);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                drain_results();
            else
                pause_sender($urandom_range(1, 250));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 6);
        end
        send_scan(open_bits, extra_open);
        burst_left--;
        phase_sent++;
    endtask

    task automatic play_keystroke();
        logic [KEY_BITS-1:0] held;
        logic [KEY_BITS-1:0] bounce;
        logic                extra_held;
        int                  r1, r2, c1, c2;
        held = '0;
        if ($urandom_range(0, 2) == 0)
        begin
            r1 = $urandom_range(0, SIDE - 1);
            r2 = (r1 + $urandom_range(1, SIDE - 1)) % SIDE;
            c1 = $urandom_range(0, SIDE - 1);
            c2 = (c1 + $urandom_range(1, SIDE - 1)) % SIDE;
            held[r1 * SIDE + c1] = 1'b1;
            held[r1 * SIDE + c2] = 1'b1;
            held[r2 * SIDE + c1] = 1'b1;
            if ($urandom_range(0, 1) == 1)
                held[r2 * SIDE + c2] = 1'b1;
        end
        repeat ($urandom_range(0, 3))
            held[$urandom_range(0, KEY_BITS - 1)] = 1'b1;
        extra_held = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 24))
        begin
            bounce = '0;
            if ($urandom_range(0, 5) == 0)
                bounce[$urandom_range(0, KEY_BITS - 1)] = 1'b1;
            feed_scan(~held ^ bounce, ~extra_held ^ ($urandom_range(0, 7) == 0));
        end
        repeat ($urandom_range(1, 6))
        begin
            bounce = '0;
            if ($urandom_range(0, 3) == 0)
                bounce[$urandom_range(0, KEY_BITS - 1)] = 1'b1;
            feed_scan(~bounce, 1'b1);
        end
    endtask

    task automatic play_noise();
        logic [KEY_BITS-1:0] a;
        logic [KEY_BITS-1:0] b;
        repeat ($urandom_range(1, 4))
        begin
            a = {$urandom, $urandom};
            b = {$urandom, $urandom};
            case ($urandom_range(0, 2))
                0: feed_scan(a, 1'($urandom_range(0, 1)));
                1: feed_scan(a | b, 1'($urandom_range(0, 1)));
                default: feed_scan(a & b, 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    task automatic test_reset_values();
        send_scan('1, 1'b1);
        send_scan(~(64'd1 << (3 * SIDE + 4)), 1'b0);
        send_scan('1, 1'b1);
        drain_results();
    endtask

    task automatic test_ghost_hold();
        logic [KEY_BITS-1:0] corner;
        write_reg(REG_GHOST_TICKS, 8'd2);
        write_reg(REG_DEBOUNCE_TICKS, 8'd2);
        corner = '0;
        corner[0]                   = 1'b1;
        corner[1]                   = 1'b1;
        corner[SIDE]                = 1'b1;
        corner[(SIDE - 1) * SIDE + SIDE - 1] = 1'b1;
        repeat (4)
            send_scan(~corner, 1'b1);
        send_scan('1, 1'b1);
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_GHOST_TICKS, 8'd0);
        write_reg(REG_DEBOUNCE_TICKS, 8'd0);
        send_scan('0, 1'b0);
        send_scan('1, 1'b1);
        send_scan({16{4'hA}}, 1'b0);
        send_scan({16{4'h5}}, 1'b1);
        send_scan('1, 1'b1);
        drain_results();
        write_reg(REG_GHOST_TICKS, 8'd255);
        write_reg(REG_DEBOUNCE_TICKS, 8'd255);
        send_scan(~(64'd1 << (5 * SIDE + 2)), 1'b0);
        drain_results();
        write_reg(REG_GHOST_TICKS, 8'd254);
        send_scan(~(64'd1 << (6 * SIDE + 6)), 1'b1);
        drain_results();
    endtask

    task automatic test_unused_index();
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'h00);
        send_scan(~(64'd1 << (2 * SIDE + 7)), 1'b0);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_reg(REG_GHOST_TICKS, 8'd3);
        write_reg(REG_DEBOUNCE_TICKS, 8'd5);
        rx_hold_req = 1'b1;
        repeat (10)
            send_scan({$urandom, $urandom}, 1'($urandom_range(0, 1)));
        wait (rx_hold_req == 1'b0);
        drain_results();
    endtask

    task automatic test_random_scans();
        logic [STATUS_W-1:0] ghost_set    [9];
        logic [STATUS_W-1:0] debounce_set [9];
        ghost_set    = '{8'd1, 8'd254, 8'd0, 8'd255, 8'd10, 8'd2, 8'd0, 8'd0, 8'd0};
        debounce_set = '{8'd0, 8'd255, 8'd0, 8'd7, 8'd25, 8'd3, 8'd0, 8'd0, 8'd0};
        for (int p = 0; p < 9; p++)
        begin
            if (p >= 6)
            begin
                ghost_set[p]    = 8'($urandom_range(0, 12));
                debounce_set[p] = 8'($urandom_range(0, 40));
            end
            drain_results();
            write_reg(REG_GHOST_TICKS, ghost_set[p]);
            write_reg(REG_DEBOUNCE_TICKS, debounce_set[p]);
            phase_sent = 0;
            burst_left = 0;
            while (phase_sent < PHASE_SCANS)
            begin
                if ($urandom_range(0, 4) == 0)
                    play_noise();
                else
                    play_keystroke();
            end
        end
    endtask

    initial
    begin
        int seg_len;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES)
                    @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                seg_len = $urandom_range(1, 200);
                m_tready <= ($urandom_range(0, 3) != 0);
                repeat (seg_len)
                    @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_reports.size() == 0)
            begin
                $error("key report transfer with no scan outstanding");
                error_count++;
            end
            else
            begin
                oldest_report = predicted_reports.pop_front();
                if (m_tdata[63:0] !== oldest_report.settled)
                begin
                    $error("settled_bits: expected %h, actual %h",
                           oldest_report.settled, m_tdata[63:0]);
                    error_count++;
                end
                if (m_tdata[127:64] !== oldest_report.pending)
                begin
                    $error("pending_bits: expected %h, actual %h",
                           oldest_report.pending, m_tdata[127:64]);
                    error_count++;
                end
                if (m_tdata[128] !== oldest_report.extra_pressed)
                begin
                    $error("extra_key_pressed: expected %b, actual %b",
                           oldest_report.extra_pressed, m_tdata[128]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #(WATCHDOG_NS);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rx_hold_req = 1'b0;
        error_count = 0;
        burst_left  = 0;
        phase_sent  = 0;
        ghost_cfg    = GHOST_TICKS_RESET;
        debounce_cfg = DEBOUNCE_TICKS_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            key_level[i]   = '0;
            bounce_left[i] = '0;
        end
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_ghost_hold();
        test_register_extremes();
        test_unused_index();
        test_backpressure();
        test_random_scans();

        drain_results();
        repeat (2 * LATENCY)
            @(posedge clk);
        if (error_count == 0 && predicted_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
